### rtl/assert_macros.svh
// Assertion macros included by the top-level RTL file of the cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, sampled on the block clock.
`define ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked in the next cycle, sampled on the block clock.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/lrupp_pkg.sv
// Package with the transaction types and codes of the probabilistic-promotion LRU cache.
package lrupp_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_PROBE  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [15:0] PERIOD_RESET   = 16'd2;
   localparam logic [6:0]  CAPACITY_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] rand_word;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        promoted;
      logic        evicted_valid;
      logic [31:0] evicted_key;
      logic        removed;
   } rsp_type;

endpackage

### rtl/lru_probabilistic_promotion.sv
// Top level of the fully associative LRU cache with probabilistic promotion.
//
// One transaction is taken while busy is low and start is high, and exactly one result is
// strobed on rsp_valid for a single cycle; the receiver cannot stall it, so it must take every
// result. Transactions are handled one at a time. All slot state lives in one memory with a
// registered read, so a transaction runs a sequential key scan, then a decision that waits for
// the bit-serial remainder unit to finish the promotion test, then any read-modify-write on
// the recency list, then the result. After reset the block clears the valid flag of every slot
// before it accepts a request; configuration writes are taken at any time and must only be
// issued while the block is idle.
module lru_probabilistic_promotion #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  lrupp_pkg::req_type              req_data,
   output logic                            rsp_valid,
   output lrupp_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lrupp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lrupp_pkg::CSR_DATA_W-1:0] csr_data
);
   import lrupp_pkg::*;

   `include "assert_macros.svh"

   localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);
   localparam logic [CNT_W-1:0] ENT_N = CNT_W'(ENTRIES);

   // Sequencer state codes.
   localparam logic [3:0] ST_CLR    = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_SCAN   = 4'd2;
   localparam logic [3:0] ST_DEC    = 4'd3;
   localparam logic [3:0] ST_U_GET  = 4'd4;
   localparam logic [3:0] ST_U_M1   = 4'd5;
   localparam logic [3:0] ST_U_M2   = 4'd6;
   localparam logic [3:0] ST_P_RD   = 4'd7;
   localparam logic [3:0] ST_P_H    = 4'd8;
   localparam logic [3:0] ST_P_SELF = 4'd9;
   localparam logic [3:0] ST_P_W    = 4'd10;
   localparam logic [3:0] ST_RESP   = 4'd11;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [IW-1:0]       newer;
      logic [IW-1:0]       older;
   } entry_type;

   // Slot memory and its registered read port.
   entry_type mem [ENTRIES];
   entry_type mem_rdata_ff;
   entry_type mem_wdata;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic mem_we;

   logic [3:0] state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [15:0] period_ff;
   logic [6:0] capacity_ff;

   logic [1:0] op_ff, op_in;
   logic [KEY_BITS-1:0] kin_ff, kin_in;
   logic match_found_ff, match_found_in, free_found_ff, free_found_in;
   logic [IW-1:0] match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [KEY_BITS-1:0] tailkey_ff, tailkey_in;

   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [IW-1:0] uslot_ff, uslot_in, tgt_ff, tgt_in;
   logic [IW-1:0] lk_new_ff, lk_new_in, lk_old_ff, lk_old_in;
   logic push_pend_ff, push_pend_in, ins_ff, ins_in;
   rsp_type rsp_ff, rsp_in;

   // Bit-serial remainder unit.
   logic [16:0] per_ff, per_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [5:0] div_cnt_ff, div_cnt_in;
   logic [16:0] div_trial;

   logic [63:0] key64, ek64;
   logic [CMP_W-1:0] cap_eff, used_ext;
   logic [IW-1:0] scan_idx;
   logic accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign key64    = {32'b0, req_data.key};
   assign ek64     = 64'(tailkey_ff);
   assign used_ext = CMP_W'(used_ff);
   assign scan_idx = IW'(scan_ff - CNT_W'(1));
   assign div_trial = {rem_ff, dvd_ff[31]};

   // Effective capacity: zero acts as one, values above the slot count are clipped.
   always_comb begin
      cap_eff = CMP_W'(capacity_ff);
      if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > ENT_C) begin
         cap_eff = ENT_C;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PERIOD:   period_ff   <= csr_data[15:0];
            REG_CAPACITY: capacity_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Sequencer, scan and list update.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      scan_in        = scan_ff;
      op_in          = op_ff;
      kin_in         = kin_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      tailkey_in     = tailkey_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      used_in        = used_ff;
      uslot_in       = uslot_ff;
      tgt_in         = tgt_ff;
      lk_new_in      = lk_new_ff;
      lk_old_in      = lk_old_ff;
      push_pend_in   = push_pend_ff;
      ins_in         = ins_ff;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = mem_rdata_ff;
      mem_raddr      = '0;

      unique case (state_ff)
         ST_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == IW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in          = req_data.op;
               kin_in         = key64[KEY_BITS-1:0];
               scan_in        = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               rsp_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Read one slot a cycle; compare the slot read in the previous cycle.
            mem_raddr = scan_ff[IW-1:0];
            scan_in   = scan_ff + CNT_W'(1);
            if (scan_ff != '0) begin
               if (mem_rdata_ff.valid && (mem_rdata_ff.key == kin_ff) && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = scan_idx;
               end
               if (!mem_rdata_ff.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = scan_idx;
               end
               if (scan_idx == tail_ff) begin
                  tailkey_in = mem_rdata_ff.key;
               end
            end
            if (scan_ff == ENT_N) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (div_cnt_ff == '0) begin
               state_in     = ST_RESP;
               rsp_in.hit   = match_found_ff;
               push_pend_in = 1'b0;
               ins_in       = 1'b0;
               unique case (op_ff)
                  OP_PROBE: ;
                  OP_REMOVE: begin
                     if (match_found_ff) begin
                        rsp_in.removed = 1'b1;
                        uslot_in  = match_idx_ff;
                        mem_raddr = match_idx_ff;
                        state_in  = ST_U_GET;
                     end
                  end
                  OP_ACCESS: begin
                     if (match_found_ff) begin
                        if (rem_ff == '0) begin
                           rsp_in.promoted = 1'b1;
                           uslot_in     = match_idx_ff;
                           tgt_in       = match_idx_ff;
                           push_pend_in = 1'b1;
                           mem_raddr    = match_idx_ff;
                           state_in     = ST_U_GET;
                        end
                     end else if ((used_ext >= cap_eff) && (used_ff != '0)) begin
                        // Full: evict the tail, then reuse the lowest free slot.
                        rsp_in.evicted_valid = 1'b1;
                        rsp_in.evicted_key   = ek64[31:0];
                        uslot_in     = tail_ff;
                        tgt_in       = (free_found_ff && (free_idx_ff < tail_ff)) ?
                                       free_idx_ff : tail_ff;
                        push_pend_in = 1'b1;
                        ins_in       = 1'b1;
                        mem_raddr    = tail_ff;
                        state_in     = ST_U_GET;
                     end else if (free_found_ff) begin
                        tgt_in   = free_idx_ff;
                        ins_in   = 1'b1;
                        state_in = ST_P_RD;
                     end
                  end
                  default: rsp_in = '0;
               endcase
            end
         end
         ST_U_GET: begin
            // Unlink the slot: clear its valid flag and patch the neighbours.
            mem_we          = 1'b1;
            mem_waddr       = uslot_ff;
            mem_wdata.valid = 1'b0;
            used_in         = used_ff - CNT_W'(1);
            state_in        = push_pend_ff ? ST_P_RD : ST_RESP;
            if (used_ff <= CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (uslot_ff == head_ff) begin
               head_in = mem_rdata_ff.older;
            end else if (uslot_ff == tail_ff) begin
               tail_in = mem_rdata_ff.newer;
            end else begin
               lk_new_in = mem_rdata_ff.newer;
               lk_old_in = mem_rdata_ff.older;
               mem_raddr = mem_rdata_ff.newer;
               state_in  = ST_U_M1;
            end
         end
         ST_U_M1: begin
            mem_we          = 1'b1;
            mem_waddr       = lk_new_ff;
            mem_wdata.older = lk_old_ff;
            mem_raddr       = lk_old_ff;
            state_in        = ST_U_M2;
         end
         ST_U_M2: begin
            mem_we          = 1'b1;
            mem_waddr       = lk_old_ff;
            mem_wdata.newer = lk_new_ff;
            state_in        = push_pend_ff ? ST_P_RD : ST_RESP;
         end
         ST_P_RD: begin
            // Push the target slot at the head of the list.
            if (used_ff == '0) begin
               tail_in  = tgt_ff;
               state_in = ST_P_SELF;
            end else begin
               mem_raddr = head_ff;
               state_in  = ST_P_H;
            end
         end
         ST_P_H: begin
            mem_we          = 1'b1;
            mem_waddr       = head_ff;
            mem_wdata.newer = tgt_ff;
            state_in        = ST_P_SELF;
         end
         ST_P_SELF: begin
            mem_raddr = tgt_ff;
            state_in  = ST_P_W;
         end
         ST_P_W: begin
            mem_we          = 1'b1;
            mem_waddr       = tgt_ff;
            mem_wdata.valid = 1'b1;
            mem_wdata.newer = tgt_ff;
            if (ins_ff) begin
               mem_wdata.key = kin_ff;
            end
            if (used_ff != '0) begin
               mem_wdata.older = head_ff;
            end
            head_in  = tgt_ff;
            used_in  = used_ff + CNT_W'(1);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Remainder of the random word by the promotion period, one bit a cycle.
   always_comb begin
      per_in     = per_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      div_cnt_in = div_cnt_ff;
      if (accept) begin
         per_in     = (period_ff == '0) ? 17'd1 : {1'b0, period_ff};
         rem_in     = '0;
         dvd_in     = req_data.rand_word;
         div_cnt_in = 6'd32;
      end else if (div_cnt_ff != '0) begin
         rem_in     = (div_trial >= per_ff) ? 16'(div_trial - per_ff) : div_trial[15:0];
         dvd_in     = {dvd_ff[30:0], 1'b0};
         div_cnt_in = div_cnt_ff - 6'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         clr_ff     <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         used_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         used_ff    <= used_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Working registers of the current transaction.
   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      op_ff          <= op_in;
      kin_ff         <= kin_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      tailkey_ff     <= tailkey_in;
      uslot_ff       <= uslot_in;
      tgt_ff         <= tgt_in;
      lk_new_ff      <= lk_new_in;
      lk_old_ff      <= lk_old_in;
      push_pend_ff   <= push_pend_in;
      ins_ff         <= ins_in;
      rsp_ff         <= rsp_in;
      per_ff         <= per_in;
      rem_ff         <= rem_in;
      dvd_ff         <= dvd_in;
   end

   // Checks on the sequencer and the results.
   `ASSERT_NEXT(a_accept_busy, accept, busy)
   `ASSERT_NEXT(a_resp_idle, rsp_valid, !busy)
   `ASSERT_IMP(a_remove_hit, rsp_valid && (rsp_data.removed || rsp_data.promoted), rsp_data.hit)
   `ASSERT_IMP(a_evict_miss, rsp_valid && rsp_data.evicted_valid, !rsp_data.hit)
   `ASSERT_IMP(a_used_bound, state_ff == ST_IDLE, used_ff <= ENT_N)

endmodule

### tb/lru_probabilistic_promotion_test.sv
// Self-checking testbench for the LRU cache with probabilistic promotion.
module lru_probabilistic_promotion_test;
   import lrupp_pkg::*;

   localparam int SLOTS = 64;
   localparam int STALL_LIMIT = 3000;
   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Mirror of the cache contents and recency list.
   logic [31:0] mirror_key[SLOTS];
   logic mirror_valid[SLOTS];
   logic [5:0] newer_link[SLOTS];
   logic [5:0] older_link[SLOTS];
   logic [5:0] newest_slot;
   logic [5:0] oldest_slot;
   int occupancy;
   logic [15:0] period_reg;
   logic [6:0] capacity_reg;

   rsp_type pending_outcomes[$];
   logic [31:0] key_pool[96];
   int errors = 0;
   int stall_cycles = 0;
   int sender_idle_pct = 0;

   lru_probabilistic_promotion DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic int lookup_slot(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (mirror_valid[i] && mirror_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int first_free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!mirror_valid[i]) return i;
      return -1;
   endfunction

   // Take a slot out of the recency list.
   function automatic void detach_slot(logic [5:0] s);
      if (occupancy <= 1) begin
         newest_slot = '0;
         oldest_slot = '0;
      end else if (s == newest_slot) begin
         newest_slot = older_link[s];
      end else if (s == oldest_slot) begin
         oldest_slot = newer_link[s];
      end else begin
         older_link[newer_link[s]] = older_link[s];
         newer_link[older_link[s]] = newer_link[s];
      end
      mirror_valid[s] = 1'b0;
      if (occupancy > 0) occupancy--;
   endfunction

   // Make a slot the most recent entry.
   function automatic void attach_newest(logic [5:0] s);
      if (occupancy == 0) begin
         oldest_slot = s;
      end else begin
         newer_link[newest_slot] = s;
         older_link[s] = newest_slot;
      end
      newer_link[s] = s;
      newest_slot = s;
      mirror_valid[s] = 1'b1;
      occupancy++;
   endfunction

   // Apply one request to the mirror and work out the cache's answer.
   function automatic rsp_type predict_outcome(req_type r);
      rsp_type o;
      int s;
      int f;
      int cap;
      logic [31:0] per;
      o = '0;
      if (r.op != OP_UNDEFINED) begin
         s = lookup_slot(r.key);
         o.hit = (s >= 0);
         if (r.op == OP_ACCESS) begin
            if (s >= 0) begin
               per = (period_reg == 0) ? 32'd1 : {16'd0, period_reg};
               if (r.rand_word % per == 0) begin
                  detach_slot(s[5:0]);
                  attach_newest(s[5:0]);
                  o.promoted = 1'b1;
               end
            end else begin
               cap = capacity_reg;
               if (cap == 0) cap = 1;
               if (cap > SLOTS) cap = SLOTS;
               if (occupancy >= cap && occupancy > 0) begin
                  o.evicted_valid = 1'b1;
                  o.evicted_key = mirror_key[oldest_slot];
                  detach_slot(oldest_slot);
               end
               f = first_free_slot();
               if (f >= 0) begin
                  mirror_key[f] = r.key;
                  attach_newest(f[5:0]);
               end
            end
         end else if (r.op == OP_REMOVE && s >= 0) begin
            detach_slot(s[5:0]);
            o.removed = 1'b1;
         end
      end
      return o;
   endfunction

   // Offer one request, holding start high until the cache takes it.
   task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] rw);
      req_type r;
      int gap;
      r.op = op;
      r.key = k;
      r.rand_word = rw;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(5, 1) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(predict_outcome(r));
   endtask

   // Let every outstanding result drain before touching the registers.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0 || busy);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_PERIOD) period_reg = value;
      else if (idx == REG_CAPACITY) capacity_reg = value[6:0];
   endtask

   // Write to an unused register, lookups, promotion, removal and the undefined operation.
   task automatic test_basic_ops();
      write_register(REG_UNUSED, 16'hFFFF);
      send_request(OP_ACCESS, 32'h0, 32'h0);
      send_request(OP_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_PROBE, 32'h0, 32'h0);
      send_request(OP_PROBE, 32'h5, 32'h0);
      send_request(OP_ACCESS, 32'h0, 32'h0);
      send_request(OP_ACCESS, 32'h0, 32'h1);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_UNDEFINED, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_UNDEFINED, 32'hFFFF_FFFF, 32'h0);
   endtask

   // Eviction at a tiny capacity, zero period, capacity lowered below occupancy.
   task automatic test_eviction();
      write_register(REG_PERIOD, 16'd0);
      write_register(REG_CAPACITY, 16'd2);
      send_request(OP_ACCESS, 32'hA, 32'h3);
      send_request(OP_ACCESS, 32'hB, 32'h3);
      send_request(OP_ACCESS, 32'hC, 32'h3);
      send_request(OP_ACCESS, 32'hB, 32'h7);
      send_request(OP_ACCESS, 32'hD, 32'h7);
      write_register(REG_CAPACITY, 16'd64);
      for (int i = 0; i < 4; i++) send_request(OP_ACCESS, 32'h100 + i, 32'h0);
      write_register(REG_CAPACITY, 16'hFF80);
      send_request(OP_ACCESS, 32'h200, 32'h0);
      write_register(REG_PERIOD, 16'hFFFF);
      send_request(OP_ACCESS, 32'h200, 32'hFFFF_0000);
      send_request(OP_ACCESS, 32'h200, 32'hFFFF_0001);
   endtask

   // Random traffic over a key set a little larger than the capacity.
   task automatic test_random_phase(logic [15:0] per, logic [15:0] cap, int count);
      int span;
      int pick;
      logic [1:0] op;
      logic [31:0] k;
      logic [31:0] rw;
      write_register(REG_PERIOD, per);
      write_register(REG_CAPACITY, cap);
      span = (cap[6:0] == 0) ? 3 : ((cap[6:0] > 80) ? 96 : cap[6:0] + 8);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         op = (pick < 55) ? OP_ACCESS : (pick < 75) ? OP_PROBE :
              (pick < 95) ? OP_REMOVE : OP_UNDEFINED;
         k = ($urandom_range(99) < 3) ? $urandom : key_pool[$urandom_range(span - 1)];
         rw = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
         send_request(op, k, rw);
      end
   endtask

   // Compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.hit !== want.hit ||
                rsp_data.promoted !== want.promoted ||
                rsp_data.evicted_valid !== want.evicted_valid ||
                rsp_data.evicted_key !== want.evicted_key ||
                rsp_data.removed !== want.removed) begin
               $display("%0t: result mismatch, expected %h, actual %h", $time, want, rsp_data);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction of any kind completes.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) mirror_valid[i] = 1'b0;
      newest_slot = '0;
      oldest_slot = '0;
      occupancy = 0;
      period_reg = PERIOD_RESET;
      capacity_reg = CAPACITY_RESET;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 14;
      test_basic_ops();
      test_eviction();
      test_random_phase(16'd1, 16'd4, 190);
      test_random_phase(16'd0, 16'd0, 190);
      test_random_phase(16'd3, 16'd127, 200);
      sender_idle_pct = 65;
      test_random_phase(16'd2, 16'd64, 190);
      test_random_phase(16'hFFFF, 16'd16, 190);
      test_random_phase(16'd4, 16'd1, 190);
      sender_idle_pct = 0;
      test_random_phase(16'd2, 16'd8, 190);
      test_random_phase(16'd5, 16'd65, 190);

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_outcomes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
